>>> rtl/core/rtufr_pkg.sv
// Package for the RTU frame receiver with CRC check.
// Holds the shared types, status codes, register indexes and defaults.
// No dependencies.
package rtufr_pkg;

  localparam int FRAME_BYTES_DEF = 128;

  localparam logic [7:0] DEVICE_ADDRESS_RST     = 8'd11;
  localparam logic [7:0] END_OF_FRAME_TICKS_RST = 8'd32;

  localparam logic       REG_DEVICE_ADDRESS     = 1'b0;
  localparam logic       REG_END_OF_FRAME_TICKS = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_ADDR_MISS   = 3'd2,
    ST_CRC_ERROR   = 3'd3,
    ST_SHORT       = 3'd4,
    ST_OVERFLOW    = 3'd5
  } status_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_length;
    logic [7:0] function_code;
    logic [7:0] slave_address;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] end_of_frame_ticks;
  } cfg_t;

endpackage

>>> rtl/core/rtufr_in_stage.sv
// Input register of the RTU frame receiver.
// Holds one accepted transaction until the frame core takes it; uses rtufr_pkg.
module rtufr_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  rtufr_pkg::in_item_t s_item,
  input  logic               take,
  output logic               valid_r,
  output rtufr_pkg::in_item_t item_r
);

  logic valid_nxt;

  assign s_ready = !valid_r || take;

  always_comb begin
    if (s_valid && s_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item_r <= s_item;
    end
  end

endmodule

>>> rtl/core/rtufr_frame_core.sv
// Frame state, CRC accumulation and end-of-frame classification.
// One transaction per cycle unless an end stalls; uses rtufr_pkg.
module rtufr_frame_core #(
  parameter int FRAME_BYTES = rtufr_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rtufr_pkg::cfg_t     cfg,
  input  logic                item_valid,
  input  rtufr_pkg::in_item_t item,
  input  logic                out_free,
  output logic                take,
  output logic                res_load,
  output rtufr_pkg::result_t  res
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [CW-1:0] FULL_COUNT  = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] SHORT_LIMIT = CW'(4);
  localparam logic [CW-1:0] HDR_LIMIT   = CW'(2);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ rtufr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic          overflowed_r, overflowed_nxt;
  logic [7:0]    idle_ticks_r, idle_ticks_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    recent0_r, recent0_nxt, recent1_r, recent1_nxt;
  logic [7:0]    hdr0_r, hdr0_nxt, hdr1_r, hdr1_nxt;

  logic [8:0]    next_idle;
  logic          frame_end;
  logic [CW+7:0] len_ext;
  rtufr_pkg::status_t status;

  assign next_idle = {1'b0, idle_ticks_r} + 9'd1;
  assign frame_end = (item.action == rtufr_pkg::ACT_TICK) && (byte_count_r != '0)
                     && (next_idle > {1'b0, cfg.end_of_frame_ticks});
  assign take      = item_valid && (!frame_end || out_free);
  assign res_load  = take && frame_end;
  assign len_ext   = {8'h00, byte_count_r};

  always_comb begin
    priority if (overflowed_r) begin
      status = rtufr_pkg::ST_OVERFLOW;
    end else if (byte_count_r < SHORT_LIMIT) begin
      status = rtufr_pkg::ST_SHORT;
    end else if (crc_r != {recent1_r, recent0_r}) begin
      status = rtufr_pkg::ST_CRC_ERROR;
    end else if (hdr0_r != cfg.device_address) begin
      status = rtufr_pkg::ST_ADDR_MISS;
    end else if (hdr1_r == rtufr_pkg::FC_READ_HOLDING || hdr1_r == rtufr_pkg::FC_READ_INPUT
                 || hdr1_r == rtufr_pkg::FC_WRITE_SINGLE
                 || hdr1_r == rtufr_pkg::FC_WRITE_MULTI) begin
      status = rtufr_pkg::ST_OK;
    end else begin
      status = rtufr_pkg::ST_UNSUPPORTED;
    end
  end

  assign res.status        = status;
  assign res.slave_address = hdr0_r;
  assign res.function_code = hdr1_r;
  assign res.frame_length  = len_ext[7:0];

  always_comb begin
    byte_count_nxt = byte_count_r;
    overflowed_nxt = overflowed_r;
    idle_ticks_nxt = idle_ticks_r;
    crc_nxt        = crc_r;
    recent0_nxt    = recent0_r;
    recent1_nxt    = recent1_r;
    hdr0_nxt       = hdr0_r;
    hdr1_nxt       = hdr1_r;
    if (take) begin
      if (item.action == rtufr_pkg::ACT_BYTE) begin
        idle_ticks_nxt = 8'd0;
        if (byte_count_r >= FULL_COUNT) begin
          overflowed_nxt = 1'b1;
        end else begin
          if (byte_count_r < HDR_LIMIT) begin
            if (byte_count_r[0]) begin
              hdr1_nxt = item.rx_byte;
            end else begin
              hdr0_nxt = item.rx_byte;
            end
          end else begin
            crc_nxt = crc_feed(crc_r, recent0_r);
          end
          recent0_nxt    = recent1_r;
          recent1_nxt    = item.rx_byte;
          byte_count_nxt = byte_count_r + CW'(1);
        end
      end else if (frame_end) begin
        byte_count_nxt = '0;
        overflowed_nxt = 1'b0;
        idle_ticks_nxt = 8'd0;
        crc_nxt        = rtufr_pkg::CRC_INIT;
        recent0_nxt    = 8'd0;
        recent1_nxt    = 8'd0;
        hdr0_nxt       = 8'd0;
        hdr1_nxt       = 8'd0;
      end else begin
        idle_ticks_nxt = next_idle[8] ? 8'hFF : next_idle[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      overflowed_r <= 1'b0;
      idle_ticks_r <= 8'd0;
      crc_r        <= rtufr_pkg::CRC_INIT;
      recent0_r    <= 8'd0;
      recent1_r    <= 8'd0;
      hdr0_r       <= 8'd0;
      hdr1_r       <= 8'd0;
    end else begin
      byte_count_r <= byte_count_nxt;
      overflowed_r <= overflowed_nxt;
      idle_ticks_r <= idle_ticks_nxt;
      crc_r        <= crc_nxt;
      recent0_r    <= recent0_nxt;
      recent1_r    <= recent1_nxt;
      hdr0_r       <= hdr0_nxt;
      hdr1_r       <= hdr1_nxt;
    end
  end

endmodule

>>> rtl/core/rtufr_out_stage.sv
// Result register of the RTU frame receiver.
// Holds one status transaction until the consumer takes it; uses rtufr_pkg.
module rtufr_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  rtufr_pkg::result_t res,
  output logic               free,
  output logic               m_valid,
  input  logic               m_ready,
  output rtufr_pkg::result_t m_res
);

  logic valid_r, valid_nxt;
  rtufr_pkg::result_t res_r;

  assign free    = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_res   = res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (m_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

>>> rtl/core/rtu_frame_receiver_crc_check.sv
// Top level of the RTU frame receiver with CRC check.
// Uses rtufr_pkg, rtufr_in_stage, rtufr_frame_core and rtufr_out_stage.
//
//  channel | direction | payload
//  in_     | slave     | tdata = rx_byte, tuser = action (0 byte, 1 tick)
//  out_    | master    | tdata = status, slave_address, function_code, frame_length
//  cfg_    | write     | index 0 device_address, index 1 end_of_frame_ticks
//
// A stalled result blocks only a frame-ending tick; otherwise one transaction is accepted
// per cycle. The frame core works on it in the cycle after the edge that registers it, and
// the out stage registers the status when the core takes the ending tick. The throughput is
// set by the single pass through the frame core. Reset is synchronous and active low.
module rtu_frame_receiver_crc_check #(
  parameter int FRAME_BYTES = rtufr_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] status, [10:3] slave_address,
                                  // [18:11] function_code, [26:19] frame_length
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  rtufr_pkg::cfg_t     cfg_r;
  rtufr_pkg::in_item_t s_item, item_r;
  rtufr_pkg::result_t  res, m_res;
  logic item_valid, take, res_load, out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address     <= rtufr_pkg::DEVICE_ADDRESS_RST;
      cfg_r.end_of_frame_ticks <= rtufr_pkg::END_OF_FRAME_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtufr_pkg::REG_DEVICE_ADDRESS:     cfg_r.device_address     <= cfg_wdata;
        rtufr_pkg::REG_END_OF_FRAME_TICKS: cfg_r.end_of_frame_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_item.action  = in_tuser;
  assign s_item.rx_byte = in_tdata;

  rtufr_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (s_item),
    .take    (take),
    .valid_r (item_valid),
    .item_r  (item_r)
  );

  rtufr_frame_core #(.FRAME_BYTES(FRAME_BYTES)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item_r),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  rtufr_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (res_load),
    .res     (res),
    .free    (out_free),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_res   (m_res)
  );

  assign out_tdata = {5'b00000, m_res};

endmodule

>>> rtl/core/rtufr_checker.sv
// Port-level checker for the RTU frame receiver, bound to the top level.
// Depends on rtu_frame_receiver_crc_check and rtufr_pkg.
module rtufr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == rtufr_pkg::ST_SHORT
    |-> out_tdata[26:19] < 8'd4 && out_tdata[26:19] != 8'd0)
    else $error("short status with a bad frame length");

  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == rtufr_pkg::ST_OK
    |-> out_tdata[18:11] == rtufr_pkg::FC_READ_HOLDING
     || out_tdata[18:11] == rtufr_pkg::FC_READ_INPUT
     || out_tdata[18:11] == rtufr_pkg::FC_WRITE_SINGLE
     || out_tdata[18:11] == rtufr_pkg::FC_WRITE_MULTI)
    else $error("ok status with an unsupported function code");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd5 && out_tdata[31:27] == 5'd0)
    else $error("bad status code or padding");

endmodule

bind rtu_frame_receiver_crc_check rtufr_checker u_rtufr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
